FILE: design/clsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsp_pkg
// Shared types, codes and constants of the crossfading loop sample player,
// including the quarter-wave cosine table used for all fade weights.
// ----------------------------------------------------------------------------
package clsp_pkg;

  // sizes
  localparam int unsigned MAX_SAMPLES       = 65536;
  localparam int unsigned MAX_OVERLAP       = 8192;
  localparam int unsigned FADE_LENGTH       = 4096;
  localparam int unsigned FADE_TABLE_POINTS = 1024;
  localparam int unsigned SAMPLE_AW         = 16;
  localparam int unsigned BANK_AW           = SAMPLE_AW + 1;
  localparam int unsigned ROM_AW            = 11;

  localparam logic [15:0] GAIN_RESET  = 16'd16384;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // transaction action codes
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_BEGIN  = 2'd1,
    ACT_RENDER = 2'd2,
    ACT_END    = 2'd3
  } action_e;

  // pair fetch and interpolate operations
  typedef enum logic [1:0] {
    OP_SAMP_A = 2'd0,
    OP_SAMP_B = 2'd1,
    OP_WCOS   = 2'd2,
    OP_WSIN   = 2'd3
  } op_e;

  // render sequencer
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_SETUP  = 12'b0000_0000_0010,
    ST_RD0    = 12'b0000_0000_0100,
    ST_RD1    = 12'b0000_0000_1000,
    ST_INTERP = 12'b0000_0001_0000,
    ST_DIV    = 12'b0000_0010_0000,
    ST_MIX0   = 12'b0000_0100_0000,
    ST_MIX1   = 12'b0000_1000_0000,
    ST_STEP   = 12'b0001_0000_0000,
    ST_WRAP   = 12'b0010_0000_0000,
    ST_GAIN   = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_e;

  typedef logic [15:0] fade_rom_t [0:FADE_TABLE_POINTS];

  // cosine of point i over 0..pi/2, Taylor series in Q30, rounded to Q15
  function automatic logic [15:0] cos_q15(input int unsigned i);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic signed [63:0] sum;
    a    = (64'(i) * HALF_PI_Q30) >> 10;
    a2   = (a * a) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    term = ((term * a2) >> 30) / 64'd2;   sum = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd12;  sum = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd30;  sum = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd56;  sum = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd90;  sum = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd132; sum = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd182; sum = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd240; sum = sum + $signed(term);
    term = ((term * a2) >> 30) / 64'd306; sum = sum - $signed(term);
    term = ((term * a2) >> 30) / 64'd380; sum = sum + $signed(term);
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    return 16'((sum + 64'sd16384) >>> 15);
  endfunction

  function automatic fade_rom_t build_fade_rom();
    fade_rom_t rom;
    int unsigned i;
    for (i = 0; i <= FADE_TABLE_POINTS; i++) begin
      rom[i] = cos_q15(i);
    end
    return rom;
  endfunction

endpackage

FILE: design/crossfading_loop_sample_player_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crossfading_loop_sample_player_core
// Two-bank looping sample player with loop-seam crossfade, equal-power
// transition fade between loops, output gain and 16-bit saturation.
// ----------------------------------------------------------------------------
// Write, begin and end transactions are taken while idle. A render does
// more work inside the seam overlap than on a plain stretch of the loop,
// and more again while an old loop fades out. The position wrap subtracts
// one loop span at a time during each bank pass. Every sample and every fade
// weight is a pair of reads from the wave memory or the cosine ROM
// followed by an interpolate step. The overlap phase comes from a
// bit-serial divider. No new transaction is taken until a render has handed
// its result to the output register. The wave memory has no reset; entries
// must be written before a loop plays them.
module crossfading_loop_sample_player_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               gain_we_i,
  input  logic [15:0]        gain_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] sample_in_i,
  input  logic [16:0]        loop_length_i,
  input  logic [18:0]        rate_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] audio_out_o,
  output logic               fading_o
);

  localparam logic [16:0] LenMax  = 17'(clsp_pkg::MAX_SAMPLES);
  localparam logic [13:0] OvMax   = 14'(clsp_pkg::MAX_OVERLAP);
  localparam logic [12:0] FadeLen = 13'(clsp_pkg::FADE_LENGTH);
  localparam logic [10:0] TabPts  = 11'(clsp_pkg::FADE_TABLE_POINTS);
  localparam clsp_pkg::fade_rom_t CosRom = clsp_pkg::build_fade_rom();

  // architectural state
  clsp_pkg::state_e state_q, state_d;
  logic        playing_q;
  logic        active_q;
  logic [12:0] fade_q;
  logic [15:0] gain_q;
  logic [16:0] len_q  [2];
  logic [18:0] step_q [2];
  logic [32:0] pos_q  [2];

  // render working registers
  logic             sel_q, pass_q, trans_q, fad_q;
  clsp_pkg::op_e    op_q;
  logic [16:0]      n_q, os_q, span_q;
  logic [13:0]      ov_q;
  logic [32:0]      p_q;
  logic [18:0]      stp_q;
  logic [15:0]      a1_q, frac_q;
  logic signed [16:0] d0_q;
  logic [13:0]      rem_q;
  logic [15:0]      dlo_q;
  logic [3:0]       cnt_q;
  logic [15:0]      t_q;
  logic signed [17:0] x_q, y_q, v_q, vp_q;
  logic signed [16:0] wc_q, ws_q;
  logic signed [35:0] acc_q;
  logic signed [15:0] g_q;

  // memories and output register
  logic signed [15:0] wave_mem [0:2*clsp_pkg::MAX_SAMPLES-1];
  logic signed [15:0] wave_rd_q;
  logic [15:0]        rom_rd_q;
  logic               out_valid_q;
  logic signed [15:0] audio_q;
  logic               fading_q;

  logic in_acc;
  assign in_stall_o = (state_q != clsp_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // begin length saturation
  logic [16:0] len_sat;
  assign len_sat = (loop_length_i > LenMax) ? LenMax : loop_length_i;

  // bank setup: overlap length and wrap span
  logic [16:0] n_s;
  logic [15:0] half_s;
  logic [13:0] ov_c;
  logic [16:0] os_c;
  always_comb begin
    n_s    = len_q[sel_q];
    half_s = n_s[16:1];
    if (half_s == 16'd0)                  ov_c = 14'd1;
    else if (half_s > {2'b00, OvMax})     ov_c = OvMax;
    else                                  ov_c = half_s[13:0];
    os_c   = n_s - {3'b000, ov_c};
  end

  // sample and weight pair addresses
  logic        is_samp, over;
  logic [32:0] os16, pb, src_pos, maxp, ps;
  logic [15:0] left;
  logic [16:0] left_inc;
  logic [15:0] right;
  logic [9:0]  idx;
  logic [15:0] a0_c, a1_c, frac_c, rd_addr;
  always_comb begin
    is_samp  = (op_q == clsp_pkg::OP_SAMP_A) || (op_q == clsp_pkg::OP_SAMP_B);
    os16     = {os_q, 16'd0};
    over     = (p_q >= os16);
    pb       = p_q - os16;
    src_pos  = (op_q == clsp_pkg::OP_SAMP_B) ? pb : p_q;
    maxp     = {1'b0, 16'(n_q - 17'd1), 16'd0};
    ps       = (src_pos > maxp) ? maxp : src_pos;
    left     = ps[31:16];
    left_inc = {1'b0, left} + 17'd1;
    right    = (left_inc < n_q) ? left_inc[15:0] : 16'(n_q - 17'd1);
    idx      = t_q[15:6];
    case (op_q)
      clsp_pkg::OP_SAMP_A, clsp_pkg::OP_SAMP_B: begin
        a0_c   = left;
        a1_c   = right;
        frac_c = ps[15:0];
      end
      clsp_pkg::OP_WCOS: begin
        a0_c   = {6'd0, idx};
        a1_c   = {5'd0, 11'({1'b0, idx} + 11'd1)};
        frac_c = {t_q[5:0], 10'd0};
      end
      default: begin
        a0_c   = {5'd0, 11'(TabPts - {1'b0, idx})};
        a1_c   = {5'd0, 11'(TabPts - {1'b0, idx} - 11'd1)};
        frac_c = {t_q[5:0], 10'd0};
      end
    endcase
    rd_addr = (state_q == clsp_pkg::ST_RD1) ? a1_q : a0_c;
  end

  // pair interpolation
  logic signed [16:0] rd_data;
  logic signed [17:0] diff;
  logic signed [34:0] iprod, irnd, ires;
  always_comb begin
    rd_data = is_samp ? 17'(wave_rd_q) : $signed({1'b0, rom_rd_q});
    diff    = rd_data - d0_q;
    iprod   = diff * $signed({1'b0, frac_q});
    irnd    = (iprod + 35'sd32768) >>> 16;
    ires    = d0_q + irnd;
  end

  // divider step and start
  logic [14:0] trial;
  logic        trial_ge;
  logic [13:0] rem_nx;
  logic [16:0] div_hi;
  logic        div_sat;
  always_comb begin
    trial    = {rem_q, dlo_q[15]};
    trial_ge = (trial >= {1'b0, ov_q});
    rem_nx   = trial_ge ? 14'(trial - {1'b0, ov_q}) : trial[13:0];
    div_hi   = pb[32:16];
    div_sat  = (div_hi >= {3'b000, ov_q});
  end

  // mixes and gain
  logic signed [35:0] mprod0, msum, mrnd, gprod, grnd;
  logic signed [15:0] gsat;
  always_comb begin
    mprod0 = x_q * wc_q;
    msum   = acc_q + y_q * ws_q;
    mrnd   = (msum + 36'sd16384) >>> 15;
    gprod  = v_q * $signed({1'b0, gain_q});
    grnd   = (gprod + 36'sd8192) >>> 14;
    if (grnd > 36'sd32767)       gsat = 16'sh7fff;
    else if (grnd < -36'sd32768) gsat = -16'sh8000;
    else                         gsat = grnd[15:0];
  end

  // position wrap
  logic [32:0] n16, span16;
  logic        need_wrap;
  assign n16       = {n_q, 16'd0};
  assign span16    = {span_q, 16'd0};
  assign need_wrap = (p_q >= n16);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clsp_pkg::ST_IDLE: begin
        if (in_acc && action_i == clsp_pkg::ACT_RENDER) begin
          state_d = active_q ? clsp_pkg::ST_SETUP : clsp_pkg::ST_DONE;
        end
      end
      clsp_pkg::ST_SETUP:  state_d = clsp_pkg::ST_RD0;
      clsp_pkg::ST_RD0:    state_d = clsp_pkg::ST_RD1;
      clsp_pkg::ST_RD1:    state_d = clsp_pkg::ST_INTERP;
      clsp_pkg::ST_INTERP: begin
        case (op_q)
          clsp_pkg::OP_SAMP_A: begin
            if (!over)        state_d = clsp_pkg::ST_STEP;
            else if (div_sat) state_d = clsp_pkg::ST_RD0;
            else              state_d = clsp_pkg::ST_DIV;
          end
          clsp_pkg::OP_WCOS: state_d = clsp_pkg::ST_RD0;
          clsp_pkg::OP_WSIN: state_d = trans_q ? clsp_pkg::ST_MIX0 : clsp_pkg::ST_RD0;
          default:           state_d = clsp_pkg::ST_MIX0;
        endcase
      end
      clsp_pkg::ST_DIV:  state_d = (cnt_q == 4'hf) ? clsp_pkg::ST_RD0 : clsp_pkg::ST_DIV;
      clsp_pkg::ST_MIX0: state_d = clsp_pkg::ST_MIX1;
      clsp_pkg::ST_MIX1: state_d = trans_q ? clsp_pkg::ST_GAIN : clsp_pkg::ST_STEP;
      clsp_pkg::ST_STEP: state_d = clsp_pkg::ST_WRAP;
      clsp_pkg::ST_WRAP: begin
        if (need_wrap)   state_d = clsp_pkg::ST_WRAP;
        else if (pass_q) state_d = clsp_pkg::ST_RD0;
        else if (fad_q)  state_d = clsp_pkg::ST_SETUP;
        else             state_d = clsp_pkg::ST_GAIN;
      end
      clsp_pkg::ST_GAIN: state_d = clsp_pkg::ST_DONE;
      clsp_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = clsp_pkg::ST_IDLE;
      end
      default: state_d = clsp_pkg::ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clsp_pkg::ST_IDLE;
      playing_q   <= 1'b0;
      active_q    <= 1'b0;
      fade_q      <= '0;
      gain_q      <= clsp_pkg::GAIN_RESET;
      len_q[0]    <= '0;
      len_q[1]    <= '0;
      step_q[0]   <= '0;
      step_q[1]   <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gain_we_i) gain_q <= gain_wdata_i;
      if (in_acc) begin
        unique case (action_i)
          clsp_pkg::ACT_WRITE: fade_q <= '0;
          clsp_pkg::ACT_BEGIN: begin
            if (loop_length_i != 17'd0) begin
              fade_q             <= active_q ? FadeLen : 13'd0;
              playing_q          <= ~playing_q;
              len_q[~playing_q]  <= len_sat;
              step_q[~playing_q] <= rate_step_i;
              pos_q[~playing_q]  <= '0;
              active_q           <= 1'b1;
            end
          end
          clsp_pkg::ACT_END: begin
            active_q <= 1'b0;
            pos_q[0] <= '0;
            pos_q[1] <= '0;
            fade_q   <= '0;
          end
          default: ;
        endcase
      end
      // position write-back and fade countdown at the end of a bank pass
      if (state_q == clsp_pkg::ST_WRAP && !need_wrap) begin
        pos_q[sel_q] <= p_q;
        if (pass_q) fade_q <= fade_q - 13'd1;
      end
      // output register: load a finished render, else drop an accepted one
      if (state_q == clsp_pkg::ST_DONE && state_d == clsp_pkg::ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // render datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      clsp_pkg::ST_IDLE: begin
        sel_q   <= playing_q;
        pass_q  <= 1'b0;
        trans_q <= 1'b0;
        fad_q   <= active_q && (fade_q != 13'd0);
        g_q     <= '0;
      end
      clsp_pkg::ST_SETUP: begin
        n_q    <= n_s;
        ov_q   <= ov_c;
        os_q   <= os_c;
        span_q <= (os_c == 17'd0) ? 17'd1 : os_c;
        p_q    <= pos_q[sel_q];
        stp_q  <= step_q[sel_q];
        op_q   <= clsp_pkg::OP_SAMP_A;
      end
      clsp_pkg::ST_RD0: begin
        a1_q   <= a1_c;
        frac_q <= frac_c;
      end
      clsp_pkg::ST_RD1: d0_q <= rd_data;
      clsp_pkg::ST_INTERP: begin
        case (op_q)
          clsp_pkg::OP_SAMP_A: begin
            x_q   <= 18'($signed(ires[16:0]));
            v_q   <= 18'($signed(ires[16:0]));
            rem_q <= div_hi[13:0];
            dlo_q <= pb[15:0];
            cnt_q <= '0;
            if (div_sat) t_q <= 16'hffff;
            op_q  <= clsp_pkg::OP_WCOS;
          end
          clsp_pkg::OP_WCOS: begin
            wc_q <= ires[16:0];
            op_q <= clsp_pkg::OP_WSIN;
          end
          clsp_pkg::OP_WSIN: begin
            ws_q <= ires[16:0];
            op_q <= clsp_pkg::OP_SAMP_B;
          end
          default: y_q <= 18'($signed(ires[16:0]));
        endcase
      end
      clsp_pkg::ST_DIV: begin
        rem_q <= rem_nx;
        dlo_q <= {dlo_q[14:0], 1'b0};
        t_q   <= {t_q[14:0], trial_ge};
        cnt_q <= cnt_q + 4'd1;
      end
      clsp_pkg::ST_MIX0: acc_q <= mprod0;
      clsp_pkg::ST_MIX1: v_q   <= mrnd[17:0];
      clsp_pkg::ST_STEP: p_q   <= p_q + {14'd0, stp_q};
      clsp_pkg::ST_WRAP: begin
        if (need_wrap) begin
          p_q <= p_q - span16;
        end else if (pass_q) begin
          // old loop done: set up the transition mix
          x_q     <= v_q;
          y_q     <= vp_q;
          trans_q <= 1'b1;
          t_q     <= {12'(FadeLen - fade_q), 4'd0};
          op_q    <= clsp_pkg::OP_WCOS;
        end else begin
          vp_q   <= v_q;
          sel_q  <= ~sel_q;
          pass_q <= 1'b1;
        end
      end
      clsp_pkg::ST_GAIN: g_q <= gsat;
      clsp_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          audio_q  <= g_q;
          fading_q <= fad_q;
        end
      end
      default: ;
    endcase
  end

  // wave memory: write from transactions, read for the sequencer
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == clsp_pkg::ACT_WRITE) begin
      wave_mem[{~playing_q, address_i}] <= sample_in_i;
    end
    wave_rd_q <= wave_mem[{sel_q, rd_addr}];
  end

  // cosine rom
  always_ff @(posedge clk_i) begin
    rom_rd_q <= CosRom[rd_addr[clsp_pkg::ROM_AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign audio_out_o = audio_q;
  assign fading_o    = fading_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) fade_q <= FadeLen)
    else $error("fade counter above fade length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (len_q[playing_q] != 17'd0))
    else $error("active loop with zero length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clsp_pkg::ST_IDLE && active_q) |->
      (pos_q[playing_q] < {len_q[playing_q], 16'd0}))
    else $error("playing position past loop end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clsp_pkg::ST_DIV) |-> (ov_q != 14'd0))
    else $error("divider running with zero overlap");

endmodule
